// ===== hw/rtl/smx_pkg.sv =====
// Shared types, constants and microcode word layout for the splitmix64 id byte generator.
package smx_pkg;

	localparam int MAX_BYTES = 64;
	localparam int BCNT_W    = 7;
	localparam int PC_W      = 4;

	localparam logic [63:0] GOLDEN_INC = 64'h9E3779B97F4A7C15;
	localparam logic [63:0] MIX_MUL_A  = 64'hBF58476D1CE4E5B9;
	localparam logic [63:0] MIX_MUL_B  = 64'h94D049BB133111EB;

	localparam logic [1:0] MODE_RAW  = 2'd0;
	localparam logic [1:0] MODE_UUID = 2'd1;
	localparam logic [1:0] MODE_MAC  = 2'd2;

	localparam logic [BCNT_W-1:0] UUID_LEN = 7'd16;
	localparam logic [BCNT_W-1:0] MAC_LEN  = 7'd6;

	localparam logic [BCNT_W-1:0] UUID_VER_IDX = 7'd6;
	localparam logic [BCNT_W-1:0] UUID_VAR_IDX = 7'd8;

	localparam logic [7:0] VER_MASK = 8'h0F;
	localparam logic [7:0] VER_BITS = 8'h40;
	localparam logic [7:0] VAR_MASK = 8'h3F;
	localparam logic [7:0] VAR_BITS = 8'h80;
	localparam logic [7:0] MAC_HEAD = 8'h02;

	localparam logic [PC_W-1:0] PC_IDLE = 4'd0;
	localparam logic [PC_W-1:0] PC_LOOP = 4'd1;

	typedef enum logic [1:0] {MUL_NONE, MUL_LL, MUL_LH, MUL_HL} mul_op_t;
	typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD_HI} acc_op_t;
	typedef enum logic [1:0] {Z_HOLD, Z_MIX30, Z_MIX27, Z_FINAL} z_op_t;
	typedef enum logic [1:0] {SEQ_NEXT, SEQ_IDLE, SEQ_EMIT} seq_op_t;

	typedef struct packed {
		mul_op_t mul;
		logic    kb;
		acc_op_t acc;
		z_op_t   zop;
		logic    st_add;
		seq_op_t seq;
	} uc_word_t;

endpackage

// ===== hw/rtl/splitmix64_id_byte_generator.sv =====
// Top level: request intake, microcode sequencer and byte output register.
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tdata: seed, mode, byte_count
//  m_      | out | m_tvalid/m_tready  | m_tdata: data_byte; m_tlast: is_last
//
// Each 64-bit generator word takes 12 sequencer steps (state add, three xor-shift
// mixes and two multiplies of three 32x32 partial products each on one shared
// multiplier), then up to 8 bytes leave at one per cycle unless the output stalls.
// Reset clears the sequencer and the output valid; one request is in flight at a time.
// A stalled output holds the emit step until the byte is taken.
module splitmix64_id_byte_generator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,  // [63:0] seed, [65:64] mode, [72:66] byte_count
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // [7:0] data_byte
	output logic        m_tlast   // is_last
);

	logic [smx_pkg::PC_W-1:0]   pc_q;
	logic [smx_pkg::BCNT_W-1:0] idx_q;
	logic [smx_pkg::BCNT_W-1:0] cnt_q;
	logic [1:0]                 mode_q;
	logic                       m_tvalid_q;
	logic [7:0]                 m_tdata_q;
	logic                       m_tlast_q;

	smx_pkg::uc_word_t          uc;
	logic [63:0]                word;
	logic [63:0]                seed;
	logic [1:0]                 mode;
	logic [smx_pkg::BCNT_W-1:0] byte_count;
	logic [smx_pkg::BCNT_W-1:0] cnt_new;
	logic                       accept;
	logic                       out_free;
	logic                       emit;
	logic [7:0]                 raw_byte;
	logic [7:0]                 fix_byte;
	logic                       last;

	assign seed       = s_tdata[63:0];
	assign mode       = s_tdata[65:64];
	assign byte_count = s_tdata[72:66];

	smx_ucode_rom u_rom (
		.pc (pc_q),
		.uc (uc)
	);

	smx_datapath u_dp (
		.clk  (clk),
		.uc   (uc),
		.load (accept),
		.seed (seed),
		.word (word)
	);

	assign s_tready = (uc.seq == smx_pkg::SEQ_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign emit     = (uc.seq == smx_pkg::SEQ_EMIT) && out_free;

	always_comb begin
		if (mode == smx_pkg::MODE_UUID) begin
			cnt_new = smx_pkg::UUID_LEN;
		end else if (mode == smx_pkg::MODE_MAC) begin
			cnt_new = smx_pkg::MAC_LEN;
		end else if (byte_count > smx_pkg::BCNT_W'(smx_pkg::MAX_BYTES)) begin
			cnt_new = smx_pkg::BCNT_W'(smx_pkg::MAX_BYTES);
		end else begin
			cnt_new = byte_count;
		end
	end

	always_comb begin
		raw_byte = 8'(word >> {idx_q[2:0], 3'b000});
		fix_byte = raw_byte;
		if (mode_q == smx_pkg::MODE_UUID && idx_q == smx_pkg::UUID_VER_IDX) begin
			fix_byte = (raw_byte & smx_pkg::VER_MASK) | smx_pkg::VER_BITS;
		end else if (mode_q == smx_pkg::MODE_UUID && idx_q == smx_pkg::UUID_VAR_IDX) begin
			fix_byte = (raw_byte & smx_pkg::VAR_MASK) | smx_pkg::VAR_BITS;
		end else if (mode_q == smx_pkg::MODE_MAC && idx_q == '0) begin
			fix_byte = smx_pkg::MAC_HEAD;
		end
		last = (idx_q + 7'd1 == cnt_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q       <= smx_pkg::PC_IDLE;
			idx_q      <= '0;
			cnt_q      <= '0;
			mode_q     <= smx_pkg::MODE_RAW;
			m_tvalid_q <= 1'b0;
		end else begin
			if (emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (uc.seq)
				smx_pkg::SEQ_IDLE: begin
					if (accept) begin
						idx_q  <= '0;
						cnt_q  <= cnt_new;
						mode_q <= mode;
						if (cnt_new != '0) begin
							pc_q <= smx_pkg::PC_LOOP;
						end
					end
				end
				smx_pkg::SEQ_EMIT: begin
					if (out_free) begin
						idx_q <= idx_q + 7'd1;
						if (last) begin
							pc_q <= smx_pkg::PC_IDLE;
						end else if (idx_q[2:0] == 3'd7) begin
							pc_q <= smx_pkg::PC_LOOP;
						end
					end
				end
				smx_pkg::SEQ_NEXT: pc_q <= pc_q + 4'd1;
				default: pc_q <= smx_pkg::PC_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_tdata_q <= fix_byte;
			m_tlast_q <= last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

endmodule

// ===== hw/rtl/smx_ucode_rom.sv =====
// Microcode program: one control word per step of the generator sequencer.
module smx_ucode_rom (
	input  logic [smx_pkg::PC_W-1:0] pc,
	output smx_pkg::uc_word_t        uc
);

	always_comb begin
		uc = '{smx_pkg::MUL_NONE, 1'b0, smx_pkg::ACC_HOLD, smx_pkg::Z_HOLD, 1'b0,
			smx_pkg::SEQ_IDLE};
		unique case (pc)
			4'd0: uc.seq = smx_pkg::SEQ_IDLE;
			4'd1: begin
				uc.st_add = 1'b1;
				uc.seq    = smx_pkg::SEQ_NEXT;
			end
			4'd2: begin
				uc.zop = smx_pkg::Z_MIX30;
				uc.seq = smx_pkg::SEQ_NEXT;
			end
			4'd3: begin
				uc.mul = smx_pkg::MUL_LL;
				uc.seq = smx_pkg::SEQ_NEXT;
			end
			4'd4: begin
				uc.mul = smx_pkg::MUL_LH;
				uc.acc = smx_pkg::ACC_LOAD;
				uc.seq = smx_pkg::SEQ_NEXT;
			end
			4'd5: begin
				uc.mul = smx_pkg::MUL_HL;
				uc.acc = smx_pkg::ACC_ADD_HI;
				uc.seq = smx_pkg::SEQ_NEXT;
			end
			4'd6: begin
				uc.acc = smx_pkg::ACC_ADD_HI;
				uc.seq = smx_pkg::SEQ_NEXT;
			end
			4'd7: begin
				uc.zop = smx_pkg::Z_MIX27;
				uc.seq = smx_pkg::SEQ_NEXT;
			end
			4'd8: begin
				uc.mul = smx_pkg::MUL_LL;
				uc.kb  = 1'b1;
				uc.seq = smx_pkg::SEQ_NEXT;
			end
			4'd9: begin
				uc.mul = smx_pkg::MUL_LH;
				uc.kb  = 1'b1;
				uc.acc = smx_pkg::ACC_LOAD;
				uc.seq = smx_pkg::SEQ_NEXT;
			end
			4'd10: begin
				uc.mul = smx_pkg::MUL_HL;
				uc.kb  = 1'b1;
				uc.acc = smx_pkg::ACC_ADD_HI;
				uc.seq = smx_pkg::SEQ_NEXT;
			end
			4'd11: begin
				uc.acc = smx_pkg::ACC_ADD_HI;
				uc.seq = smx_pkg::SEQ_NEXT;
			end
			4'd12: begin
				uc.zop = smx_pkg::Z_FINAL;
				uc.seq = smx_pkg::SEQ_NEXT;
			end
			4'd13: uc.seq = smx_pkg::SEQ_EMIT;
			default: uc.seq = smx_pkg::SEQ_IDLE;
		endcase
	end

endmodule

// ===== hw/rtl/smx_datapath.sv =====
// Generator datapath: state, mixer, shared 32x32 multiplier and 64-bit accumulator.
module smx_datapath (
	input  logic              clk,
	input  smx_pkg::uc_word_t uc,
	input  logic              load,
	input  logic [63:0]       seed,
	output logic [63:0]       word
);

	logic [63:0] st_q;
	logic [63:0] z_q;
	logic [63:0] prod_q;
	logic [63:0] acc_q;
	logic [63:0] word_q;
	logic [63:0] k;
	logic [31:0] ma;
	logic [31:0] mb;

	always_comb begin
		k = uc.kb ? smx_pkg::MIX_MUL_B : smx_pkg::MIX_MUL_A;
		unique case (uc.mul)
			smx_pkg::MUL_LL: begin
				ma = z_q[31:0];
				mb = k[31:0];
			end
			smx_pkg::MUL_LH: begin
				ma = z_q[31:0];
				mb = k[63:32];
			end
			smx_pkg::MUL_HL: begin
				ma = z_q[63:32];
				mb = k[31:0];
			end
			smx_pkg::MUL_NONE: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			st_q <= seed;
		end else if (uc.st_add) begin
			st_q <= st_q + smx_pkg::GOLDEN_INC;
		end
		if (uc.mul != smx_pkg::MUL_NONE) begin
			prod_q <= {32'b0, ma} * {32'b0, mb};
		end
		unique case (uc.acc)
			smx_pkg::ACC_LOAD:   acc_q <= prod_q;
			smx_pkg::ACC_ADD_HI: acc_q <= acc_q + {prod_q[31:0], 32'b0};
			default:             acc_q <= acc_q;
		endcase
		unique case (uc.zop)
			smx_pkg::Z_MIX30: z_q <= st_q ^ (st_q >> 30);
			smx_pkg::Z_MIX27: z_q <= acc_q ^ (acc_q >> 27);
			smx_pkg::Z_FINAL: word_q <= acc_q ^ (acc_q >> 31);
			smx_pkg::Z_HOLD:  z_q <= z_q;
		endcase
	end

	assign word = word_q;

endmodule
